FILE: design/pcc_pkg.sv
package pcc_pkg;

  localparam int unsigned CRC_W    = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned WINDOW_BYTES = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef logic [CRC_W-1:0] crc_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [OFFSET_W-1:0] offset_t;

endpackage

FILE: design/page_crc32_check.sv
// Page CRC-32 checker. Page bytes enter one word per cycle on the in_ channel,
// lowest address first, with in_last_byte on the final byte. A reflected CRC-32
// (poly 0xEDB88320, init and final xor all ones) runs over every byte except the
// four at cfg_data (the checksum offset), which are captured little-endian as the
// stored checksum. On the last byte one word leaves on the out_ channel with the
// final CRC and a match flag, and the checker rearms for the next page. One byte
// is taken every cycle; the byte CRC step sits between the running state and a
// single output register, and a new byte is taken while a result waits when that
// result is being taken in the same cycle. Pages longer than PAGE_BYTES wrap the
// byte position to zero. The offset should be written only between pages.
module page_crc32_check
  import pcc_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [11:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_crc_value,
  output logic          out_checksum_ok
);

  localparam int unsigned POS_W = $clog2(PAGE_BYTES);
  localparam int unsigned CMP_W = (POS_W > OFFSET_W) ? POS_W + 1 : OFFSET_W + 1;

  offset_t            offset_r;
  crc_t               crc_r, crc_nxt;
  crc_t               stored_r, stored_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  crc_t               out_crc_r, out_crc_nxt;
  logic               out_ok_r, out_ok_nxt;

  crc_t               crc_step;
  logic [CMP_W-1:0]   pos_ext, off_ext, diff;
  logic               in_window;
  logic               accept;
  crc_t               fin;
  crc_t               byte_mask, byte_ins;

  pcc_crc8 u_crc8 (
    .crc_in  (crc_r),
    .data_in (in_data_byte),
    .crc_out (crc_step)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  assign pos_ext   = CMP_W'(pos_r);
  assign off_ext   = CMP_W'(offset_r);
  assign diff      = pos_ext - off_ext;
  assign in_window = (pos_ext >= off_ext) && (diff < CMP_W'(WINDOW_BYTES));

  assign byte_mask = crc_t'(8'hFF) << {diff[1:0], 3'b000};
  assign byte_ins  = crc_t'(in_data_byte) << {diff[1:0], 3'b000};

  always_comb begin
    crc_nxt       = crc_r;
    stored_nxt    = stored_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_crc_nxt   = out_crc_r;
    out_ok_nxt    = out_ok_r;
    fin           = '0;
    if (accept) begin
      if (in_window) begin
        stored_nxt = (stored_r & ~byte_mask) | byte_ins;
      end else begin
        crc_nxt = crc_step;
      end
      fin = crc_nxt ^ CRC_ONES;
      if (in_last_byte) begin
        out_valid_nxt = 1'b1;
        out_crc_nxt   = fin;
        out_ok_nxt    = (fin == stored_nxt);
        crc_nxt       = CRC_ONES;
        stored_nxt    = '0;
        pos_nxt       = '0;
      end else if (pos_r == POS_W'(PAGE_BYTES - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      crc_r       <= CRC_ONES;
      stored_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        offset_r <= cfg_data;
      end
      crc_r       <= crc_nxt;
      stored_r    <= stored_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_crc_r <= out_crc_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_crc_value   = out_crc_r;
  assign out_checksum_ok = out_ok_r;

endmodule

FILE: design/pcc_crc8.sv
module pcc_crc8
  import pcc_pkg::*;
(
  input  crc_t  crc_in,
  input  byte_t data_in,
  output crc_t  crc_out
);

  crc_t c;

  // one reflected byte step, eight shift/xor stages on the low byte
  always_comb begin
    c = {{(CRC_W-BYTE_W){1'b0}}, crc_in[BYTE_W-1:0] ^ data_in};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c ^ (crc_in >> BYTE_W);
  end

endmodule

FILE: dv/page_crc32_check_tb.sv
module page_crc32_check_tb
  import pcc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct {
    crc_t crc;
    logic ok;
  } page_result_t;

  class crc_scoreboard;
    crc_t running;
    crc_t stored;
    offset_t offset;
    int unsigned pos;
    page_result_t expected_q[$];
    int unsigned errors;

    function new();
      offset = '0;
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      running = CRC_ONES;
      stored = '0;
      pos = 0;
    endfunction

    function crc_t crc_update(crc_t c, byte_t b);
      crc_t t;
      t = c ^ {24'd0, b};
      repeat (8) t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
      return t;
    endfunction

    // one accepted input word
    function void note_byte(byte_t b, logic last);
      int unsigned sh;
      page_result_t r;
      if (pos >= offset && pos < offset + WINDOW_BYTES) begin
        sh = (pos - offset) * 8;
        stored[sh +: 8] = b;
      end else begin
        running = crc_update(running, b);
      end
      if (last) begin
        r.crc = running ^ CRC_ONES;
        r.ok = (r.crc == stored);
        expected_q.push_back(r);
        rearm();
      end else begin
        pos = (pos + 1 >= PAGE_BYTES) ? 0 : pos + 1;
      end
    endfunction

    // one accepted output word
    function void check_result(crc_t crc, logic ok);
      page_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t unexpected result crc=%08h ok=%0b", $realtime, crc, ok);
        return;
      end
      r = expected_q.pop_front();
      if (crc !== r.crc || ok !== r.ok) begin
        errors++;
        if (errors <= 10)
          $display("%0t mismatch: expected crc=%08h ok=%0b, actual crc=%08h ok=%0b",
                   $realtime, r.crc, r.ok, crc, ok);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_crc_value;
  logic        out_checksum_ok;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  crc_scoreboard sb = new;

  always #1 clk = ~clk;

  page_crc32_check #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_crc_value  (out_crc_value),
    .out_checksum_ok(out_checksum_ok)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_crc_value, out_checksum_ok);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic write_offset(offset_t v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.offset = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(byte_t b, logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_page(ref byte_t pg[$]);
    for (int i = 0; i < pg.size(); i++)
      send_byte(pg[i], i == pg.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // random page; when sealed, the window holds the crc of the other bytes
  function automatic void make_page(int len, int off, bit sealed, ref byte_t pg[$]);
    crc_t c;
    pg.delete();
    for (int i = 0; i < len; i++) pg.push_back(byte_t'($urandom));
    if (sealed) begin
      c = CRC_ONES;
      for (int i = 0; i < len; i++)
        if (!(i >= off && i < off + WINDOW_BYTES)) c = sb.crc_update(c, pg[i]);
      c ^= CRC_ONES;
      for (int k = 0; k < WINDOW_BYTES; k++)
        if (off + k < len) pg[off + k] = c[8*k +: 8];
    end
  endfunction

  initial begin
    byte_t pg[$];
    offset_t phase_offset[8];
    int unsigned send_pct[4] = '{0, 48, 0, 14};
    int unsigned recv_pct[4] = '{0, 0, 48, 14};
    int off, len, kind, sent, idx;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pages of one to four bytes inside the window, extremes of the byte value
    write_offset(12'd0);
    pg = '{8'h00};
    send_page(pg);
    pg = '{8'hFF};
    send_page(pg);
    pg = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_page(pg);
    wait_drained();

    write_offset(12'd4);
    make_page(8, 4, 1'b1, pg);
    send_page(pg);
    // short pages ending inside or at the start of the window
    pg = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A};
    send_page(pg);
    pg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_page(pg);
    wait_drained();

    phase_offset[0] = 12'd0;
    phase_offset[1] = 12'd4092;
    phase_offset[7] = 12'd4095;
    for (int i = 2; i < 7; i++) phase_offset[i] = offset_t'($urandom_range(1, 32));

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = send_pct[ph % 4];
      recv_stall_pct = recv_pct[ph % 4];
      off = phase_offset[ph];
      write_offset(phase_offset[ph]);
      sent = 0;
      while (sent < 225) begin
        kind = $urandom_range(9);
        if (off <= 64 && kind <= 7)
          len = off + WINDOW_BYTES + $urandom_range(24);
        else
          len = $urandom_range(1, 48);
        make_page(len, off, kind <= 7, pg);
        if (kind >= 6 && kind <= 7) begin
          idx = $urandom_range(len - 1);
          pg[idx][$urandom_range(7)] = ~pg[idx][$urandom_range(7)];
        end
        send_page(pg);
        sent += len;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
